### rtl/assert_macros.svh
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dbbl_pkg.sv
// ----------------------------------------------------------------------------
// dbbl_pkg
// Types, register map and reset constants of the debounced button blinker.
// ----------------------------------------------------------------------------
`default_nettype none

package dbbl_pkg;

   // Configuration port geometry
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
   localparam logic [2:0] REG_FAST       = 3'd1;
   localparam logic [2:0] REG_SLOW       = 3'd2;
   localparam logic [2:0] REG_SYNC       = 3'd3;
   localparam logic [2:0] REG_FIRST_LVL  = 3'd4;
   localparam logic [2:0] REG_SECOND_LVL = 3'd5;

   // Register reset values
   localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;
   localparam logic [15:0] FAST_RST       = 16'd100;
   localparam logic [15:0] SLOW_RST       = 16'd1000;
   localparam logic [15:0] SYNC_RST       = 16'd500;
   localparam logic        FIRST_LVL_RST  = 1'b0;
   localparam logic        SECOND_LVL_RST = 1'b1;

   // Released levels of the buttons after reset
   localparam logic FIRST_IDLE_LEVEL  = 1'b1;
   localparam logic SECOND_IDLE_LEVEL = 1'b0;

   // Blink modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_FAST = 2'd1;
   localparam logic [1:0] MODE_SLOW = 2'd2;
   localparam logic [1:0] MODE_SYNC = 2'd3;

   typedef struct packed {
      logic first_raw;
      logic second_raw;
   } req_type;

   typedef struct packed {
      logic       red_on;
      logic       blue_on;
      logic [1:0] blink_mode;
      logic       first_press;
      logic       second_press;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] fast_period;
      logic [15:0] slow_period;
      logic [15:0] sync_period;
      logic        first_active_level;
      logic        second_active_level;
   } cfg_type;

   // Debouncer status toward the mode logic
   typedef struct packed {
      logic changed;
      logic stable;
   } btn_type;

endpackage

`default_nettype wire

### rtl/debounced_button_led_blink_mode_core.sv
// ----------------------------------------------------------------------------
// debounced_button_led_blink_mode_core
// Flow: an accepted request is held in the input register and moves into the
// result register when that is free or rsp_ready is high; throughput is one
// request per cycle while rsp_ready holds, set by the single tick update between the registers.
// Reset: synchronous, clears valids, mode, LEDs and timer, sets button state to
// the idle levels and loads the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_button_led_blink_mode_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire dbbl_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output dbbl_pkg::rsp_type                  rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [dbbl_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [dbbl_pkg::DATA_W-1:0]   pwdata,
   output logic      [dbbl_pkg::DATA_W-1:0]   prdata,
   output logic                               pready
);

   dbbl_pkg::cfg_type cfg;
   dbbl_pkg::btn_type first_btn, second_btn;
   dbbl_pkg::rsp_type result;

   logic              in_valid_ff, in_valid_in;
   dbbl_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   dbbl_pkg::rsp_type out_data_ff;
   logic              move;

   // Move the held request into the result register when there is room
   assign move        = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready   = ~in_valid_ff | move;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~move);
   assign out_valid_in = move | (out_valid_ff & ~rsp_ready);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   dbbl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dbbl_debounce u_first (
      .clock          (clock),
      .reset          (reset),
      .advance        (move),
      .idle_level     (dbbl_pkg::FIRST_IDLE_LEVEL),
      .raw            (in_data_ff.first_raw),
      .debounce_ticks (cfg.debounce_ticks),
      .status         (first_btn)
   );

   dbbl_debounce u_second (
      .clock          (clock),
      .reset          (reset),
      .advance        (move),
      .idle_level     (dbbl_pkg::SECOND_IDLE_LEVEL),
      .raw            (in_data_ff.second_raw),
      .debounce_ticks (cfg.debounce_ticks),
      .status         (second_btn)
   );

   dbbl_blink u_blink (
      .clock      (clock),
      .reset      (reset),
      .advance    (move),
      .first_btn  (first_btn),
      .second_btn (second_btn),
      .cfg        (cfg),
      .result     (result)
   );

   // Hold the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         out_data_ff <= result;
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEXT(a_move_shows_result, clock, reset, move, rsp_valid, "moved request has no result")
   `ASSERT_IMPLIES(a_alt_one_led, clock, reset, rsp_valid && (rsp_data.blink_mode == dbbl_pkg::MODE_FAST || rsp_data.blink_mode == dbbl_pkg::MODE_SLOW), !(rsp_data.red_on && rsp_data.blue_on), "both LEDs lit in alternating mode")
   `ASSERT_IMPLIES(a_none_dark, clock, reset, rsp_valid && rsp_data.blink_mode == dbbl_pkg::MODE_NONE, !rsp_data.red_on && !rsp_data.blue_on, "LED lit with no mode")
   `ASSERT_IMPLIES(a_first_press_fast, clock, reset, rsp_valid && rsp_data.first_press && !rsp_data.second_press, rsp_data.blink_mode == dbbl_pkg::MODE_FAST, "first press did not select fast mode")

endmodule

`default_nettype wire

### rtl/dbbl_csr.sv
// ----------------------------------------------------------------------------
// dbbl_csr
// APB-style register file holding debounce time, blink periods and levels.
// ----------------------------------------------------------------------------
`default_nettype none

module dbbl_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [dbbl_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [dbbl_pkg::DATA_W-1:0]   pwdata,
   output logic      [dbbl_pkg::DATA_W-1:0]   prdata,
   output logic                               pready,
   output dbbl_pkg::cfg_type                  cfg
);

   dbbl_pkg::cfg_type cfg_ff;
   dbbl_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index  = paddr[dbbl_pkg::ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            dbbl_pkg::REG_DEBOUNCE:   cfg_in.debounce_ticks      = pwdata[7:0];
            dbbl_pkg::REG_FAST:       cfg_in.fast_period         = pwdata[15:0];
            dbbl_pkg::REG_SLOW:       cfg_in.slow_period         = pwdata[15:0];
            dbbl_pkg::REG_SYNC:       cfg_in.sync_period         = pwdata[15:0];
            dbbl_pkg::REG_FIRST_LVL:  cfg_in.first_active_level  = pwdata[0];
            dbbl_pkg::REG_SECOND_LVL: cfg_in.second_active_level = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= dbbl_pkg::DEBOUNCE_RST;
         cfg_ff.fast_period         <= dbbl_pkg::FAST_RST;
         cfg_ff.slow_period         <= dbbl_pkg::SLOW_RST;
         cfg_ff.sync_period         <= dbbl_pkg::SYNC_RST;
         cfg_ff.first_active_level  <= dbbl_pkg::FIRST_LVL_RST;
         cfg_ff.second_active_level <= dbbl_pkg::SECOND_LVL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (index)
         dbbl_pkg::REG_DEBOUNCE:   prdata = {24'd0, cfg_ff.debounce_ticks};
         dbbl_pkg::REG_FAST:       prdata = {16'd0, cfg_ff.fast_period};
         dbbl_pkg::REG_SLOW:       prdata = {16'd0, cfg_ff.slow_period};
         dbbl_pkg::REG_SYNC:       prdata = {16'd0, cfg_ff.sync_period};
         dbbl_pkg::REG_FIRST_LVL:  prdata = {31'd0, cfg_ff.first_active_level};
         dbbl_pkg::REG_SECOND_LVL: prdata = {31'd0, cfg_ff.second_active_level};
         default:                  prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/dbbl_debounce.sv
// ----------------------------------------------------------------------------
// dbbl_debounce
// One-button debouncer: quiet counter, last raw sample and stable level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbbl_debounce (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       idle_level,
   input  wire logic       raw,
   input  wire logic [7:0] debounce_ticks,
   output dbbl_pkg::btn_type status
);

   logic       last_ff, last_in;
   logic       stable_ff, stable_in;
   logic [7:0] count_ff, count_in;
   logic       changed;

   // Restart on a raw change, else count up and saturate
   always_comb begin
      last_in = raw;
      if (raw != last_ff) begin
         count_in = '0;
      end else if (count_ff != 8'hFF) begin
         count_in = count_ff + 8'd1;
      end else begin
         count_in = count_ff;
      end
      changed   = (count_in > debounce_ticks) && (stable_ff != raw);
      stable_in = changed ? raw : stable_ff;
   end

   assign status.changed = changed;
   assign status.stable  = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= idle_level;
         stable_ff <= idle_level;
         count_ff  <= '0;
      end else if (advance) begin
         last_ff   <= last_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/dbbl_blink.sv
// ----------------------------------------------------------------------------
// dbbl_blink
// Mode selection from press events and the LED blink timer.
// ----------------------------------------------------------------------------
`default_nettype none

module dbbl_blink (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire dbbl_pkg::btn_type first_btn,
   input  wire dbbl_pkg::btn_type second_btn,
   input  wire dbbl_pkg::cfg_type cfg,
   output dbbl_pkg::rsp_type      result
);

   logic [1:0]  mode_ff, mode_in;
   logic        red_ff, red_in;
   logic        blue_ff, blue_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        first_held, second_held;
   logic        first_press, second_press;
   logic [1:0]  pick;
   logic        pick_valid;
   logic [15:0] period;

   assign first_held   = (first_btn.stable == cfg.first_active_level);
   assign second_held  = (second_btn.stable == cfg.second_active_level);
   assign first_press  = first_btn.changed & first_held;
   assign second_press = second_btn.changed & second_held;

   // Choose a mode from this tick's presses and held levels
   always_comb begin
      pick_valid = 1'b1;
      if (first_press && !second_press) begin
         pick = dbbl_pkg::MODE_FAST;
      end else if (second_press && !first_press) begin
         pick = dbbl_pkg::MODE_SLOW;
      end else if (first_held && second_held) begin
         pick = dbbl_pkg::MODE_SYNC;
      end else begin
         pick       = mode_ff;
         pick_valid = 1'b0;
      end
   end

   // Advance timer, apply mode change, then step the LEDs on expiry
   always_comb begin
      elapsed_in = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
      mode_in    = mode_ff;
      red_in     = red_ff;
      blue_in    = blue_ff;
      if (pick_valid && (pick != mode_ff)) begin
         mode_in    = pick;
         red_in     = 1'b0;
         blue_in    = 1'b0;
         elapsed_in = '0;
      end
      unique case (mode_in)
         dbbl_pkg::MODE_FAST: period = cfg.fast_period;
         dbbl_pkg::MODE_SLOW: period = cfg.slow_period;
         default:             period = cfg.sync_period;
      endcase
      if ((mode_in != dbbl_pkg::MODE_NONE) && (elapsed_in >= period)) begin
         elapsed_in = '0;
         if (mode_in == dbbl_pkg::MODE_SYNC) begin
            if (red_in && blue_in) begin
               red_in  = 1'b0;
               blue_in = 1'b0;
            end else begin
               red_in  = 1'b1;
               blue_in = 1'b1;
            end
         end else if (!red_in && !blue_in) begin
            red_in = 1'b1;
         end else if (red_in && !blue_in) begin
            red_in  = 1'b0;
            blue_in = 1'b1;
         end else if (!red_in && blue_in) begin
            red_in  = 1'b1;
            blue_in = 1'b0;
         end
      end
   end

   assign result.red_on       = red_in;
   assign result.blue_on      = blue_in;
   assign result.blink_mode   = mode_in;
   assign result.first_press  = first_press;
   assign result.second_press = second_press;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= dbbl_pkg::MODE_NONE;
         red_ff     <= 1'b0;
         blue_ff    <= 1'b0;
         elapsed_ff <= '0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         red_ff     <= red_in;
         blue_ff    <= blue_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

`default_nettype wire
